>>> rtl/text_console_engine_top_assert.svh
// Assertion macros for the text console engine checker.
`ifndef TEXT_CONSOLE_ENGINE_TOP_ASSERT_SVH
`define TEXT_CONSOLE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define TCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define TCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tce_pkg.sv
package tce_pkg;

  localparam int CMD_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int COLOR_W = 8;
  localparam int OFS_W   = 11;
  localparam int CELL_W  = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT_CURSOR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUT_AT     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam int TAB_STOP = 8;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
  localparam logic [CELL_W-1:0]  INIT_CELL   = 16'h0720;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PLAN,
    S_EXEC,
    S_SCROLL,
    S_CLEAR,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic item_load;
    logic plan_en;
    logic exec;
    logic sweep_clr;
    logic fill_step;
    logic fill_init;
    logic scroll_step;
    logic out_load;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic plan_scroll;
    logic plan_clear;
    logic fill_last;
    logic scroll_last;
  } ctl_sts_t;

endpackage

>>> rtl/tce_in_if.sv
interface tce_in_if;
  logic                             valid;
  logic                             ready;
  logic [tce_pkg::CMD_W-1:0]        cmd;
  logic [tce_pkg::CHAR_W-1:0]       char_code;
  logic [tce_pkg::COL_W-1:0]        col;
  logic [tce_pkg::ROW_W-1:0]        row;
  logic [tce_pkg::COLOR_W-1:0]      cell_color;

  modport source (output valid, cmd, char_code, col, row, cell_color, input ready);
  modport sink   (input valid, cmd, char_code, col, row, cell_color, output ready);
endinterface

>>> rtl/tce_out_if.sv
interface tce_out_if;
  logic                        valid;
  logic                        ready;
  logic [tce_pkg::COL_W-1:0]   cursor_col;
  logic [tce_pkg::ROW_W-1:0]   cursor_row;
  logic [tce_pkg::OFS_W-1:0]   cursor_offset;
  logic [tce_pkg::CELL_W-1:0]  cell_value;
  logic                        scrolled;

  modport source (output valid, cursor_col, cursor_row, cursor_offset, cell_value, scrolled,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_offset, cell_value, scrolled,
                  output ready);
endinterface

>>> rtl/text_console_engine_top.sv
// Text console engine: character-cell screen memory with a cursor.
// in_ch  : command items (cmd, char_code, col, row, cell_color), valid/ready.
// out_ch : one result item per command (cursor, offset, cell read, scroll flag).
// cfg_we/cfg_wdata: text colour register, to be written by the user only while
// the block is idle; the block itself does not enforce it.
// The engine takes a new command only after the previous one has been through
// the controller's sequence accept -> plan -> memory access -> result load.
// A scroll copies one cell per cycle through the one read and one write port;
// clear writes every cell.
// Reset: cursor to home, colour 0x07, then a fill pass writes 0x0720 to every
// cell; in_ch.ready stays low during it.
// Stall: the result sits in an output register; a new command is still
// accepted, and its result waits until the previous one is taken.
module text_console_engine_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst,
  tce_in_if.sink                       in_ch,
  tce_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [tce_pkg::COLOR_W-1:0]  cfg_wdata
);

  tce_pkg::ctl_cmd_t ctl_cmd;
  tce_pkg::ctl_sts_t ctl_sts;

  // sequencer: fill, plan, access, scroll/clear sweep, result hand-off
  tce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (ctl_sts),
    .cmd       (ctl_cmd)
  );

  // cursor, colour, screen memory and result register
  tce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctl_cmd),
    .sts           (ctl_sts),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_cmd        (in_ch.cmd),
    .in_char_code  (in_ch.char_code),
    .in_col        (in_ch.col),
    .in_row        (in_ch.row),
    .in_cell_color (in_ch.cell_color),
    .cursor_col    (out_ch.cursor_col),
    .cursor_row    (out_ch.cursor_row),
    .cursor_offset (out_ch.cursor_offset),
    .cell_value    (out_ch.cell_value),
    .scrolled      (out_ch.scrolled)
  );

endmodule

>>> rtl/tce_ctrl.sv
module tce_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tce_pkg::ctl_sts_t sts,
  output tce_pkg::ctl_cmd_t cmd
);

  tce_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tce_pkg::S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      tce_pkg::S_INIT: begin
        // power-up fill of the screen memory
        cmd.fill_step = 1'b1;
        cmd.fill_init = 1'b1;
        if (sts.fill_last) state_next = tce_pkg::S_IDLE;
      end
      tce_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = tce_pkg::S_PLAN;
        end
      end
      tce_pkg::S_PLAN: begin
        cmd.plan_en = 1'b1;
        state_next  = tce_pkg::S_EXEC;
      end
      tce_pkg::S_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.sweep_clr = 1'b1;
        if (sts.plan_scroll)     state_next = tce_pkg::S_SCROLL;
        else if (sts.plan_clear) state_next = tce_pkg::S_CLEAR;
        else                     state_next = tce_pkg::S_DONE;
      end
      tce_pkg::S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.scroll_last) state_next = tce_pkg::S_DONE;
      end
      tce_pkg::S_CLEAR: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) state_next = tce_pkg::S_DONE;
      end
      tce_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = tce_pkg::S_IDLE;
        end
      end
      default: state_next = tce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load)  out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else               out_valid_next = out_valid;
  end

endmodule

>>> rtl/tce_datapath.sv
module tce_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tce_pkg::ctl_cmd_t             cmd,
  output tce_pkg::ctl_sts_t             sts,
  input  logic                          cfg_we,
  input  logic [tce_pkg::COLOR_W-1:0]   cfg_wdata,
  input  logic [tce_pkg::CMD_W-1:0]     in_cmd,
  input  logic [tce_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tce_pkg::COL_W-1:0]     in_col,
  input  logic [tce_pkg::ROW_W-1:0]     in_row,
  input  logic [tce_pkg::COLOR_W-1:0]   in_cell_color,
  output logic [tce_pkg::COL_W-1:0]     cursor_col,
  output logic [tce_pkg::ROW_W-1:0]     cursor_row,
  output logic [tce_pkg::OFS_W-1:0]     cursor_offset,
  output logic [tce_pkg::CELL_W-1:0]    cell_value,
  output logic                          scrolled
);

  localparam int CELLS       = COLUMNS * ROWS;
  localparam int AW          = $clog2(CELLS);
  localparam int CW          = $clog2(CELLS + 1);
  localparam int SCROLL_SPAN = CELLS - COLUMNS;
  localparam int FW          = tce_pkg::ROW_W + tce_pkg::COL_W;
  localparam int COL_W       = tce_pkg::COL_W;
  localparam int ROW_W       = tce_pkg::ROW_W;
  localparam int CELL_W      = tce_pkg::CELL_W;

  // captured item
  logic [tce_pkg::CMD_W-1:0]   i_cmd;
  logic [tce_pkg::CHAR_W-1:0]  i_char;
  logic [COL_W-1:0]            i_col;
  logic [ROW_W-1:0]            i_row;
  logic [tce_pkg::COLOR_W-1:0] i_color;

  logic [COL_W-1:0]            cur_col;
  logic [ROW_W-1:0]            cur_row;
  logic [tce_pkg::COLOR_W-1:0] text_color;
  logic [CELL_W-1:0]           blank;

  // plan register
  logic [COL_W-1:0]  p_col;
  logic [ROW_W-1:0]  p_row;
  logic [AW-1:0]     p_addr;
  logic [CELL_W-1:0] p_wdata;
  logic              p_wr, p_rd, p_scroll, p_clear;

  // plan decode
  logic [COL_W:0]    col_inc, tab_col;
  logic              in_range, nl;
  logic [COL_W-1:0]  n_col, a_col;
  logic [ROW_W-1:0]  n_row, a_row;
  logic [CELL_W-1:0] n_wdata;
  logic              n_wr, n_rd, n_scroll, n_clear;
  logic [FW-1:0]     a_full, ofs_full;

  logic [CW-1:0]     sweep, sweep_m1, rd_ptr;

  logic [CELL_W-1:0] mem [CELLS];
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, rdata;

  assign blank = {text_color, tce_pkg::CH_SPACE};

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      i_cmd   <= in_cmd;
      i_char  <= in_char_code;
      i_col   <= in_col;
      i_row   <= in_row;
      i_color <= in_cell_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tce_pkg::COLOR_RESET;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.exec) begin
      cur_col <= p_col;
      cur_row <= p_row;
    end
  end

  always_comb begin
    col_inc  = {1'b0, cur_col} + (COL_W+1)'(1);
    tab_col  = ({1'b0, cur_col} + (COL_W+1)'(tce_pkg::TAB_STOP))
               & ~(COL_W+1)'(tce_pkg::TAB_STOP - 1);
    in_range = ({1'b0, i_col} < (COL_W+1)'(COLUMNS)) && ({1'b0, i_row} < (ROW_W+1)'(ROWS));
    nl       = 1'b0;
    n_col    = cur_col;
    n_row    = cur_row;
    a_col    = cur_col;
    a_row    = cur_row;
    n_wdata  = {text_color, i_char};
    n_wr     = 1'b0;
    n_rd     = 1'b0;
    n_scroll = 1'b0;
    n_clear  = 1'b0;
    case (i_cmd)
      tce_pkg::CMD_PUT_CURSOR: begin
        case (i_char)
          tce_pkg::CH_NEWLINE: nl = 1'b1;
          tce_pkg::CH_RETURN:  n_col = '0;
          tce_pkg::CH_TAB: begin
            if (tab_col >= (COL_W+1)'(COLUMNS)) nl = 1'b1;
            else n_col = tab_col[COL_W-1:0];
          end
          tce_pkg::CH_BACKSPACE: begin
            // nothing at column zero
            if (cur_col != '0) begin
              n_col   = cur_col - COL_W'(1);
              a_col   = cur_col - COL_W'(1);
              n_wdata = blank;
              n_wr    = 1'b1;
            end
          end
          default: begin
            n_wr = 1'b1;
            if (col_inc >= (COL_W+1)'(COLUMNS)) nl = 1'b1;
            else n_col = col_inc[COL_W-1:0];
          end
        endcase
      end
      tce_pkg::CMD_PUT_AT: begin
        if (in_range) begin
          a_col   = i_col;
          a_row   = i_row;
          n_wdata = {i_color, i_char};
          n_wr    = 1'b1;
        end
      end
      tce_pkg::CMD_SET_CURSOR: begin
        if (in_range) begin
          n_col = i_col;
          n_row = i_row;
        end
      end
      tce_pkg::CMD_CLEAR: begin
        n_col   = '0;
        n_row   = '0;
        n_clear = 1'b1;
      end
      tce_pkg::CMD_READ: begin
        if (in_range) begin
          a_col = i_col;
          a_row = i_row;
          n_rd  = 1'b1;
        end
      end
      default: ;
    endcase
    // newline: past the bottom row the screen scrolls, cursor stays on it
    if (nl) begin
      n_col = '0;
      if (cur_row == ROW_W'(ROWS - 1)) n_scroll = 1'b1;
      else n_row = cur_row + ROW_W'(1);
    end
  end

  assign a_full   = FW'(a_row) * FW'(COLUMNS) + FW'(a_col);
  assign ofs_full = FW'(cur_row) * FW'(COLUMNS) + FW'(cur_col);

  always_ff @(posedge clk) begin
    if (cmd.plan_en) begin
      p_col    <= n_col;
      p_row    <= n_row;
      p_addr   <= a_full[AW-1:0];
      p_wdata  <= n_wdata;
      p_wr     <= n_wr;
      p_rd     <= n_rd;
      p_scroll <= n_scroll;
      p_clear  <= n_clear;
    end
  end

  // sweep counter for fill and scroll
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.fill_step || cmd.scroll_step) begin
      sweep <= sweep + CW'(1);
    end
  end

  assign sweep_m1 = sweep - CW'(1);
  assign rd_ptr   = sweep + CW'(COLUMNS);

  assign sts.plan_scroll = p_scroll;
  assign sts.plan_clear  = p_clear;
  assign sts.fill_last   = (sweep == CW'(CELLS - 1));
  assign sts.scroll_last = (sweep == CW'(CELLS));

  // scroll: read one row ahead, write the previous cycle's data one row up;
  // the bottom row takes blanks
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = p_addr;
    mem_raddr = p_addr;
    mem_wdata = p_wdata;
    if (cmd.exec) begin
      mem_we = p_wr;
      mem_re = p_rd;
    end else if (cmd.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = sweep[AW-1:0];
      mem_wdata = cmd.fill_init ? tce_pkg::INIT_CELL : blank;
    end else if (cmd.scroll_step) begin
      mem_re    = (sweep < CW'(SCROLL_SPAN));
      mem_raddr = rd_ptr[AW-1:0];
      mem_we    = (sweep != '0);
      mem_waddr = sweep_m1[AW-1:0];
      mem_wdata = (sweep <= CW'(SCROLL_SPAN)) ? rdata : blank;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cursor_col    <= cur_col;
      cursor_row    <= cur_row;
      cursor_offset <= ofs_full[tce_pkg::OFS_W-1:0];
      cell_value    <= p_rd ? rdata : '0;
      scrolled      <= p_scroll;
    end
  end

endmodule

>>> rtl/tce_checker.sv
`include "text_console_engine_top_assert.svh"

module tce_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tce_pkg::COL_W-1:0]   cursor_col,
  input logic [tce_pkg::ROW_W-1:0]   cursor_row,
  input logic [tce_pkg::OFS_W-1:0]   cursor_offset
);

  localparam int FW = tce_pkg::ROW_W + tce_pkg::COL_W;

  logic [FW-1:0] ofs_calc;
  assign ofs_calc = FW'(cursor_row) * FW'(COLUMNS) + FW'(cursor_col);

  // one command in flight: no acceptance right after one
  `TCE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
                   "command accepted while another is in flight")

  `TCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
                   "result dropped before it was taken")

  `TCE_ASSERT_NOW(a_cursor_bounds,
                  out_valid,
                  (32'(cursor_col) < COLUMNS) && (32'(cursor_row) < ROWS),
                  "reported cursor off screen")

  `TCE_ASSERT_NOW(a_offset_match, out_valid,
                  cursor_offset == ofs_calc[tce_pkg::OFS_W-1:0],
                  "cursor offset disagrees with row and column")

endmodule

bind text_console_engine_top tce_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tce_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .cursor_col    (out_ch.cursor_col),
  .cursor_row    (out_ch.cursor_row),
  .cursor_offset (out_ch.cursor_offset)
);
